### src/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### src/pda_pkg.sv
// Shared types and constants of the pushdown automaton recognizer.
package pda_pkg;

   // Default sizes of the automaton.
   localparam int NUM_STATES_DEF    = 16;
   localparam int NUM_SYMBOLS_DEF   = 16;
   localparam int STACK_DEPTH_DEF   = 64;
   localparam int MAX_PUSH_DEF      = 4;
   localparam int MAX_EPS_STEPS_DEF = 64;

   // Stream widths.
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Request operation codes.
   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_SYMBOL = 2'd1,
      OP_END    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Verdict codes.
   localparam logic [1:0] VERDICT_REJECT = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
   localparam logic [1:0] VERDICT_STUCK  = 2'd2;
   localparam logic [1:0] VERDICT_LIMIT  = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_START_STATE  = 2'd0;
   localparam logic [1:0] CSR_START_SYMBOL = 2'd1;
   localparam logic [1:0] CSR_ACCEPT_MASK  = 2'd2;

   // One transition table entry.
   typedef struct packed {
      logic        valid;
      logic [3:0]  next_state;
      logic [2:0]  count;
      logic [15:0] symbols;
   } entry_type;

   // Command kinds handed from the front to the back.
   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_SYMBOL,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   symbol;
      logic [3:0]   key_state;
      logic         key_epsilon;
      logic [3:0]   key_top;
      entry_type    entry;
   } cmd_type;

endpackage

### src/pda_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pda_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### src/pda_front.sv
// Front part: accepts requests, drops void ones and queues commands.
module pda_front #(
   parameter int NUM_STATES  = 16,
   parameter int NUM_SYMBOLS = 16,
   parameter int MAX_PUSH    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [pda_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pda_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                       clearing,
   output logic                       cmd_valid,
   output pda_pkg::cmd_type           cmd_out,
   input  logic                       cmd_pop
);
   import pda_pkg::*;

   op_type      op;
   logic [3:0]  symbol, key_state, key_top, next_state;
   logic        key_epsilon, entry_valid;
   logic [2:0]  push_count, count_sat;
   logic [15:0] push_symbols;
   logic        range_ok, keep, push;
   cmd_type     cmd_new;
   cmd_type     q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0]  count_ff, count_in, wr_pos;

   // Unpack the request.
   assign op           = op_type'(req_tuser[1:0]);
   assign symbol       = req_tdata[3:0];
   assign key_state    = req_tdata[7:4];
   assign key_epsilon  = req_tdata[8];
   assign key_top      = req_tdata[12:9];
   assign entry_valid  = req_tdata[13];
   assign next_state   = req_tdata[17:14];
   assign push_count   = req_tdata[20:18];
   assign push_symbols = req_tdata[36:21];

   // Classify: unknown ops and out-of-range table keys are dropped here.
   always_comb begin
      range_ok = (32'(key_state) < NUM_STATES) && (32'(key_top) < NUM_SYMBOLS)
         && (key_epsilon || (32'(symbol) < NUM_SYMBOLS));
      keep = (op == OP_SYMBOL) || (op == OP_END) || ((op == OP_WRITE) && range_ok);
      count_sat = (32'(push_count) > MAX_PUSH) ? 3'(MAX_PUSH) : push_count;
      cmd_new.symbol      = symbol;
      cmd_new.key_state   = key_state;
      cmd_new.key_epsilon = key_epsilon;
      cmd_new.key_top     = key_top;
      cmd_new.entry       = '0;
      if (entry_valid) begin
         cmd_new.entry = '{valid: 1'b1, next_state: next_state, count: count_sat,
                           symbols: push_symbols};
      end
      case (op)
         OP_WRITE:  cmd_new.kind = CMD_WRITE;
         OP_SYMBOL: cmd_new.kind = CMD_SYMBOL;
         default:   cmd_new.kind = CMD_END;
      endcase
   end

   assign req_tready = (count_ff != 2'd2) && !clearing;
   assign push       = req_tvalid && req_tready && keep;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd_out    = q0_ff;

   // Two-entry command queue, head in slot 0.
   always_comb begin
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      count_in = count_ff;
      wr_pos   = count_ff;
      if (cmd_pop && cmd_valid) begin
         q0_in    = q1_ff;
         wr_pos   = count_ff - 2'd1;
         count_in = count_ff - 2'd1;
      end
      if (push) begin
         if (wr_pos == 2'd0) begin
            q0_in = cmd_new;
         end else begin
            q1_in = cmd_new;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end
endmodule

### src/pda_back.sv
// Back part: transition table, stack and the move sequencer.
module pda_back #(
   parameter int NUM_STATES    = 16,
   parameter int NUM_SYMBOLS   = 16,
   parameter int STACK_DEPTH   = 64,
   parameter int MAX_EPS_STEPS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   input  pda_pkg::cmd_type                cmd_in,
   output logic                            cmd_pop,
   output logic                            clearing,
   input  logic                            csr_valid,
   input  logic [pda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pda_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pda_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import pda_pkg::*;

   localparam int SW  = $clog2(NUM_STATES);
   localparam int YW  = $clog2(NUM_SYMBOLS + 1);
   localparam int TW  = $clog2(NUM_SYMBOLS);
   localparam int TAW = SW + YW + TW;
   localparam int AW  = $clog2(STACK_DEPTH);
   localparam int PW  = $clog2(STACK_DEPTH + 1);
   localparam int EW  = $clog2(MAX_EPS_STEPS + 1);
   localparam logic [YW-1:0] EPS_SLOT = YW'(NUM_SYMBOLS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_TOP, S_DEC, S_PUSH, S_REPORT
   } state_type;

   state_type       state_ff, state_in;
   logic [TAW-1:0]  clr_ff, clr_in;
   cmd_type         cur_ff, cur_in;
   logic [3:0]      st_ff, st_in, top_ff, top_in;
   logic [PW-1:0]   sp_ff, sp_in;
   logic            fresh_ff, fresh_in, halted_ff, halted_in;
   logic [1:0]      code_ff, code_in, verdict_ff, verdict_in;
   logic [EW-1:0]   eps_ff, eps_in;
   logic            phase_ff, phase_in, keyok_ff, keyok_in, done_ff, done_in;
   logic [2:0]      cnt_ff, cnt_in, nib_idx;
   logic [15:0]     syms_ff, syms_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [3:0]      start_state_ff, start_symbol_ff;
   logic [15:0]     accept_mask_ff;

   logic            tab_we;
   logic [TAW-1:0]  tab_waddr, tab_raddr;
   entry_type       tab_wdata, tab_rdata;
   logic            stk_we;
   logic [AW-1:0]   stk_waddr, stk_raddr;
   logic [3:0]      stk_wdata, stk_rdata;

   logic            hit, ovf, acc, is_sym;
   logic [PW:0]     need;

   function automatic logic [TAW-1:0] tab_addr(logic [3:0] st, logic [YW-1:0] slot,
                                                logic [3:0] top);
      tab_addr = {SW'(st), slot, TW'(top)};
   endfunction

   function automatic logic key_ok(logic [3:0] st, logic eps, logic [3:0] sym,
                                   logic [3:0] top);
      key_ok = (32'(st) < NUM_STATES) && (32'(top) < NUM_SYMBOLS)
         && (eps || (32'(sym) < NUM_SYMBOLS));
   endfunction

   pda_ram #(.WIDTH($bits(entry_type)), .DEPTH(2 ** TAW)) u_table (
      .clock(clock), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
      .rd_addr(tab_raddr), .rd_data(tab_rdata)
   );

   pda_ram #(.WIDTH(4), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
      .rd_addr(stk_raddr), .rd_data(stk_rdata)
   );

   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Move decision terms for the entry just read.
   always_comb begin
      hit     = tab_rdata.valid && keyok_ff;
      need    = (PW + 1)'(sp_ff) + (PW + 1)'(tab_rdata.count);
      ovf     = need > (PW + 1)'(STACK_DEPTH + 1);
      acc     = accept_mask_ff[st_ff];
      is_sym  = (cur_ff.kind == CMD_SYMBOL);
      nib_idx = cnt_ff - 3'd1;
   end

   // Sequencer next state and memory controls.
   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;     cur_in = cur_ff;
      st_in = st_ff;        top_in = top_ff;     sp_in = sp_ff;
      fresh_in = fresh_ff;  halted_in = halted_ff;  code_in = code_ff;
      verdict_in = verdict_ff;  eps_in = eps_ff;  phase_in = phase_ff;
      keyok_in = keyok_ff;  done_in = done_ff;   cnt_in = cnt_ff;
      syms_in = syms_ff;    rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd_pop = 1'b0;
      tab_we = 1'b0;  tab_waddr = clr_ff;  tab_wdata = '0;
      tab_raddr = tab_addr(st_ff, EPS_SLOT, top_ff);
      stk_we = 1'b0;  stk_waddr = AW'(sp_ff);  stk_wdata = start_symbol_ff;
      stk_raddr = AW'(sp_ff - PW'(1));
      case (state_ff)
         // Clear the table after reset, entry by entry in address order.
         S_CLEAR: begin
            tab_we = 1'b1;
            clr_in = clr_ff + TAW'(1);
            if (clr_ff == {TAW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         // Take the next command.
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_in;
               if (cmd_in.kind == CMD_WRITE) begin
                  tab_we    = 1'b1;
                  tab_waddr = tab_addr(cmd_in.key_state,
                     cmd_in.key_epsilon ? EPS_SLOT : YW'(cmd_in.symbol), cmd_in.key_top);
                  tab_wdata = cmd_in.entry;
               end else begin
                  eps_in = '0;
                  if (fresh_ff) begin
                     fresh_in  = 1'b0;
                     st_in     = start_state_ff;
                     stk_we    = 1'b1;
                     stk_waddr = '0;
                     sp_in     = PW'(1);
                     halted_in = 1'b0;
                     code_in   = VERDICT_REJECT;
                     state_in  = S_CHECK;
                  end else if (halted_ff) begin
                     verdict_in = code_ff;
                     state_in   = (cmd_in.kind == CMD_END) ? S_REPORT : S_IDLE;
                  end else begin
                     state_in = S_CHECK;
                  end
               end
            end
         end
         // Empty stack test, then read the top.
         S_CHECK: begin
            phase_in = !is_sym;
            if (sp_ff == '0) begin
               if (is_sym) begin
                  halted_in = 1'b1;
                  code_in   = VERDICT_STUCK;
                  state_in  = S_IDLE;
               end else begin
                  verdict_in = VERDICT_STUCK;
                  state_in   = S_REPORT;
               end
            end else begin
               state_in = S_TOP;
            end
         end
         // Top symbol is here: look up the first key.
         S_TOP: begin
            top_in    = stk_rdata;
            tab_raddr = tab_addr(st_ff, phase_ff ? EPS_SLOT : YW'(cur_ff.symbol), stk_rdata);
            keyok_in  = key_ok(st_ff, phase_ff, cur_ff.symbol, stk_rdata);
            state_in  = S_DEC;
         end
         // Decide on the entry read.
         S_DEC: begin
            if (!phase_ff) begin
               if (hit) begin
                  if (ovf) begin
                     halted_in = 1'b1;
                     code_in   = VERDICT_LIMIT;
                     state_in  = S_IDLE;
                  end else begin
                     sp_in = sp_ff - PW'(1);  st_in = tab_rdata.next_state;
                     cnt_in = tab_rdata.count;  syms_in = tab_rdata.symbols;
                     done_in = 1'b1;  state_in = S_PUSH;
                  end
               end else begin
                  phase_in  = 1'b1;
                  tab_raddr = tab_addr(st_ff, EPS_SLOT, top_ff);
                  keyok_in  = key_ok(st_ff, 1'b1, cur_ff.symbol, top_ff);
               end
            end else if (!hit) begin
               if (is_sym) begin
                  halted_in = 1'b1;
                  code_in   = VERDICT_STUCK;
                  state_in  = S_IDLE;
               end else begin
                  verdict_in = acc ? VERDICT_ACCEPT : VERDICT_REJECT;
                  state_in   = S_REPORT;
               end
            end else if (!is_sym && acc) begin
               verdict_in = VERDICT_ACCEPT;
               state_in   = S_REPORT;
            end else if ((32'(eps_ff) >= MAX_EPS_STEPS) || ovf) begin
               if (is_sym) begin
                  halted_in = 1'b1;
                  code_in   = VERDICT_LIMIT;
                  state_in  = S_IDLE;
               end else begin
                  verdict_in = VERDICT_LIMIT;
                  state_in   = S_REPORT;
               end
            end else begin
               eps_in = eps_ff + EW'(1);
               sp_in = sp_ff - PW'(1);  st_in = tab_rdata.next_state;
               cnt_in = tab_rdata.count;  syms_in = tab_rdata.symbols;
               done_in = 1'b0;  state_in = S_PUSH;
            end
         end
         // Push the new symbols, deepest first.
         S_PUSH: begin
            if (cnt_ff == 3'd0) begin
               state_in = done_ff ? S_IDLE : S_CHECK;
            end else begin
               stk_we    = 1'b1;
               stk_wdata = nib_idx[2] ? 4'd0 : syms_ff[{nib_idx[1:0], 2'b00} +: 4];
               sp_in     = sp_ff + PW'(1);
               cnt_in    = cnt_ff - 3'd1;
            end
         end
         // Load the verdict once the output register is free.
         S_REPORT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, 7'(sp_ff), st_ff, verdict_ff};
               fresh_in     = 1'b1;
               halted_in    = 1'b0;
               code_in      = VERDICT_REJECT;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         sp_ff           <= '0;
         st_ff           <= 4'd0;
         fresh_ff        <= 1'b1;
         halted_ff       <= 1'b0;
         code_ff         <= VERDICT_REJECT;
         rsp_valid_ff    <= 1'b0;
         start_state_ff  <= 4'd0;
         start_symbol_ff <= 4'd0;
         accept_mask_ff  <= 16'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sp_ff        <= sp_in;
         st_ff        <= st_in;
         fresh_ff     <= fresh_in;
         halted_ff    <= halted_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
         // Configuration writes.
         if (csr_valid) begin
            case (csr_index)
               CSR_START_STATE:  start_state_ff  <= csr_data[3:0];
               CSR_START_SYMBOL: start_symbol_ff <= csr_data[3:0];
               CSR_ACCEPT_MASK:  accept_mask_ff  <= csr_data;
               default: ;
            endcase
         end
      end
      cur_ff      <= cur_in;
      top_ff      <= top_in;
      verdict_ff  <= verdict_in;
      eps_ff      <= eps_in;
      phase_ff    <= phase_in;
      keyok_ff    <= keyok_in;
      done_ff     <= done_in;
      cnt_ff      <= cnt_in;
      syms_ff     <= syms_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

### src/pushdown_automaton_recognizer.sv
// Top level of the deterministic pushdown automaton recognizer.
//
//   channel   ports          direction  payload
//   req       req_t*         in         tuser: op; tdata: key, entry and symbol fields
//   rsp       rsp_t*         out        tdata: verdict, final_state, final_depth
//   csr       csr_*          in         csr_index, csr_data
//
// After reset the table, 2**(clog2(NUM_STATES)+clog2(NUM_SYMBOLS+1)+clog2(NUM_SYMBOLS))
// entries (8192 by default), is cleared one entry a cycle, with no request taken.
// A taken request waits in a two-entry queue until the back is idle; a table write
// is issued as the back takes it. Per move of a symbol or end request the sequencer reads the
// stack top, then the table entry (again for the epsilon key if the symbol key misses), then
// pushes the new symbols one at a time; a verdict is loaded once the output register is free.
module pushdown_automaton_recognizer #(
   parameter int NUM_STATES    = pda_pkg::NUM_STATES_DEF,
   parameter int NUM_SYMBOLS   = pda_pkg::NUM_SYMBOLS_DEF,
   parameter int STACK_DEPTH   = pda_pkg::STACK_DEPTH_DEF,
   parameter int MAX_PUSH      = pda_pkg::MAX_PUSH_DEF,
   parameter int MAX_EPS_STEPS = pda_pkg::MAX_EPS_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // symbol[3:0] key_state[7:4] key_epsilon[8] key_top[12:9] entry_valid[13]
   // next_state[17:14] push_count[20:18] push_symbols[36:21], zeros above
   input  logic [pda_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op[1:0]
   input  logic [pda_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // verdict[1:0] final_state[5:2] final_depth[12:6], zeros above
   output logic [pda_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pda_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pda_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pda_pkg::*;

   logic    cmd_valid, cmd_pop, clearing;
   cmd_type cmd;

   // Registers take a write in any cycle outside reset.
   assign csr_ready = 1'b1;

   pda_front #(
      .NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS), .MAX_PUSH(MAX_PUSH)
   ) u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .clearing(clearing),
      .cmd_valid(cmd_valid), .cmd_out(cmd), .cmd_pop(cmd_pop)
   );

   pda_back #(
      .NUM_STATES(NUM_STATES), .NUM_SYMBOLS(NUM_SYMBOLS),
      .STACK_DEPTH(STACK_DEPTH), .MAX_EPS_STEPS(MAX_EPS_STEPS)
   ) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_in(cmd),
      .cmd_pop(cmd_pop), .clearing(clearing), .csr_valid(csr_valid),
      .csr_index(csr_index), .csr_data(csr_data), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule

### src/pda_checker.sv
// Port-level checks of the recognizer and their binding.
`include "assert_macros.svh"

module pda_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [pda_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   // A stalled verdict stays put.
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   // Verdict padding bits are zero.
   `ASSERT_CLK(a_rsp_pad, clock, reset, rsp_tvalid |-> (rsp_tdata[15:13] == 3'b000))
   // The table clear holds off requests right after reset.
   `ASSERT_CLK_ALWAYS(a_clear_gate, clock, reset |=> !req_tready)
endmodule

bind pushdown_automaton_recognizer pda_checker u_pda_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
